@@ src/dstf_pkg.sv @@
// dstf_pkg: shared constants, character codes, power-of-ten table and job flags
// for the decimal string to fixed-point converter.
// No dependencies.
package dstf_pkg;

  // Default configuration
  localparam int FRAC_BITS_DEF       = 16;
  localparam int MAX_FRAC_DIGITS_DEF = 9;

  // Result format
  localparam int VALUE_W = 32;
  localparam int MAG_W   = 34;  // magnitude before clamping, room for the rounding carry
  localparam logic [30:0] MAG_LIMIT = 31'h7FFF_FFFF;

  // Character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Powers of ten, indexed by fraction digit count
  localparam int POW_IDX_W = 5;
  localparam logic [63:0] POW10 [0:18] = '{
    64'd1,
    64'd10,
    64'd100,
    64'd1000,
    64'd10000,
    64'd100000,
    64'd1000000,
    64'd10000000,
    64'd100000000,
    64'd1000000000,
    64'd10000000000,
    64'd100000000000,
    64'd1000000000000,
    64'd10000000000000,
    64'd100000000000000,
    64'd1000000000000000,
    64'd10000000000000000,
    64'd100000000000000000,
    64'd1000000000000000000
  };

  // Per-string status handed from the parser to the converter
  typedef struct packed {
    logic err;   // grammar broken
    logic neg;   // leading minus seen
    logic sat;   // integer part saturated
  } job_flags_t;

endpackage

@@ src/dstf_front.sv @@
// dstf_front: character parser. Classifies each character, keeps the integer
// and fraction accumulators, and emits one job per terminated string.
// Depends on dstf_pkg.
module dstf_front
  import dstf_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
  parameter int INT_W           = (FRAC_BITS >= 31) ? 1 : 31 - FRAC_BITS,
  parameter int FRAC_W          = $clog2(POW10[MAX_FRAC_DIGITS]),
  parameter int CNT_W           = $clog2(MAX_FRAC_DIGITS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              char_valid,   // accepted beat
  input  logic [7:0]        char_code,
  output logic              job_push,
  output job_flags_t        job_flags,
  output logic [INT_W-1:0]  job_int,
  output logic [FRAC_W-1:0] job_frac,
  output logic [CNT_W-1:0]  job_cnt
);

  localparam logic [31:0] INT_LIMIT = {1'b0, MAG_LIMIT} >> FRAC_BITS;
  localparam int N_W = INT_W + 4;
  localparam int F_W = FRAC_W + 4;

  logic              first_r, first_nxt;
  logic              neg_r, neg_nxt;
  logic              point_r, point_nxt;
  logic              lastpt_r, lastpt_nxt;
  logic              bad_r, bad_nxt;
  logic              sat_r, sat_nxt;
  logic [INT_W-1:0]  int_r, int_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              is_term, is_digit;
  logic [3:0]        digit;
  logic [N_W-1:0]    int_ext, int_times10;
  logic [F_W-1:0]    frac_ext, frac_times10;

  assign is_term  = (char_code == CHAR_NUL);
  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign digit    = char_code[3:0];

  // x*10 + d as shift-and-add
  assign int_ext      = N_W'(int_r);
  assign int_times10  = (int_ext << 3) + (int_ext << 1) + N_W'(digit);
  assign frac_ext     = F_W'(frac_r);
  assign frac_times10 = (frac_ext << 3) + (frac_ext << 1) + F_W'(digit);

  // Job handed to the queue on the terminator
  assign job_push      = char_valid && is_term;
  assign job_flags.err = bad_r || lastpt_r;
  assign job_flags.neg = neg_r;
  assign job_flags.sat = sat_r;
  assign job_int       = int_r;
  assign job_frac      = frac_r;
  assign job_cnt       = cnt_r;

  // Parser state update
  always_comb begin
    first_nxt  = first_r;
    neg_nxt    = neg_r;
    point_nxt  = point_r;
    lastpt_nxt = lastpt_r;
    bad_nxt    = bad_r;
    sat_nxt    = sat_r;
    int_nxt    = int_r;
    frac_nxt   = frac_r;
    cnt_nxt    = cnt_r;
    if (char_valid) begin
      if (is_term) begin
        first_nxt  = 1'b1;
        neg_nxt    = 1'b0;
        point_nxt  = 1'b0;
        lastpt_nxt = 1'b0;
        bad_nxt    = 1'b0;
        sat_nxt    = 1'b0;
        int_nxt    = '0;
        frac_nxt   = '0;
        cnt_nxt    = '0;
      end else begin
        first_nxt  = 1'b0;
        lastpt_nxt = 1'b0;
        priority if (char_code == CHAR_MINUS && first_r) begin
          neg_nxt = 1'b1;
        end else if (is_digit) begin
          if (!point_r) begin
            if (!sat_r) begin
              if (32'(int_times10) > INT_LIMIT) begin
                sat_nxt = 1'b1;
                int_nxt = INT_LIMIT[INT_W-1:0];
              end else begin
                int_nxt = int_times10[INT_W-1:0];
              end
            end
          end else if (32'(cnt_r) < 32'(MAX_FRAC_DIGITS)) begin
            frac_nxt = frac_times10[FRAC_W-1:0];
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end else if (char_code == CHAR_POINT) begin
          if (point_r) bad_nxt = 1'b1;
          point_nxt  = 1'b1;
          lastpt_nxt = 1'b1;
        end else begin
          bad_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 1'b1;
      neg_r    <= 1'b0;
      point_r  <= 1'b0;
      lastpt_r <= 1'b0;
      bad_r    <= 1'b0;
      sat_r    <= 1'b0;
      int_r    <= '0;
      frac_r   <= '0;
      cnt_r    <= '0;
    end else begin
      first_r  <= first_nxt;
      neg_r    <= neg_nxt;
      point_r  <= point_nxt;
      lastpt_r <= lastpt_nxt;
      bad_r    <= bad_nxt;
      sat_r    <= sat_nxt;
      int_r    <= int_nxt;
      frac_r   <= frac_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ src/dstf_job_queue.sv @@
// dstf_job_queue: two-entry register queue between parser and converter.
// Depends on dstf_pkg (header import only).
module dstf_job_queue
  import dstf_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [0:1];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ src/dstf_back.sv @@
// dstf_back: converter. Scales the fraction by 2^FRAC_BITS / 10^count with a
// bit-per-cycle restoring divider, rounds, saturates, applies the sign, and
// holds the result in the output register. Depends on dstf_pkg.
module dstf_back
  import dstf_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
  parameter int INT_W           = (FRAC_BITS >= 31) ? 1 : 31 - FRAC_BITS,
  parameter int FRAC_W          = $clog2(POW10[MAX_FRAC_DIGITS]),
  parameter int CNT_W           = $clog2(MAX_FRAC_DIGITS + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      job_empty,
  output logic                      job_pop,
  input  job_flags_t                job_flags,
  input  logic [INT_W-1:0]          job_int,
  input  logic [FRAC_W-1:0]         job_frac,
  input  logic [CNT_W-1:0]          job_cnt,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_format_error,
  output logic                      out_overflow
);

  localparam int Q_W    = FRAC_BITS + 1;
  localparam int DCNT_W = $clog2(FRAC_BITS + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_ROUND, S_OUT} state_t;

  state_t              state_r, state_nxt;
  job_flags_t          flags_r, flags_nxt;
  logic [INT_W-1:0]    int_r, int_nxt;
  logic [FRAC_W-1:0]   den_r, den_nxt;
  logic [FRAC_W-1:0]   rem_r, rem_nxt;
  logic [Q_W-1:0]      q_r, q_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [30:0]         mag_r, mag_nxt;
  logic                ovf_r, ovf_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic                err_out_r, err_out_nxt;
  logic                ovf_out_r, ovf_out_nxt;

  logic [FRAC_W-1:0]   den_load;
  logic [FRAC_W:0]     rem_shift;
  logic                rem_ge;
  logic [FRAC_W:0]     rem_diff;
  logic [Q_W:0]        q_inc;
  logic [MAG_W-1:0]    mag_sum;
  logic                slot_free;

  assign den_load  = POW10[POW_IDX_W'(job_cnt)][FRAC_W-1:0];
  assign rem_shift = {rem_r, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, den_r};
  assign rem_diff  = rem_shift - {1'b0, den_r};
  // round half up: (q + 1) >> 1
  assign q_inc     = {1'b0, q_r} + (Q_W + 1)'(1);
  assign mag_sum   = (MAG_W'(int_r) << FRAC_BITS) + MAG_W'(q_inc[Q_W:1]);
  assign slot_free = !out_valid_r || out_pop;

  assign job_pop          = (state_r == S_IDLE) && !job_empty;
  assign out_empty        = !out_valid_r;
  assign out_value        = value_r;
  assign out_format_error = err_out_r;
  assign out_overflow     = ovf_out_r;

  // Sequencer: load, divide, round, deliver
  always_comb begin
    state_nxt     = state_r;
    flags_nxt     = flags_r;
    int_nxt       = int_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    dcnt_nxt      = dcnt_r;
    mag_nxt       = mag_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_pop;
    value_nxt     = value_r;
    err_out_nxt   = err_out_r;
    ovf_out_nxt   = ovf_out_r;
    unique case (state_r)
      S_IDLE: begin
        if (!job_empty) begin
          flags_nxt = job_flags;
          int_nxt   = job_int;
          den_nxt   = den_load;
          rem_nxt   = (job_frac >= den_load) ? den_load - FRAC_W'(1) : job_frac;
          q_nxt     = '0;
          dcnt_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // one quotient bit per cycle
        rem_nxt  = rem_ge ? rem_diff[FRAC_W-1:0] : rem_shift[FRAC_W-1:0];
        q_nxt    = {q_r[Q_W-2:0], rem_ge};
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(FRAC_BITS)) state_nxt = S_ROUND;
      end
      S_ROUND: begin
        ovf_nxt = 1'b0;
        priority if (flags_r.err) begin
          mag_nxt = '0;
        end else if (flags_r.sat) begin
          mag_nxt = MAG_LIMIT;
          ovf_nxt = 1'b1;
        end else if (mag_sum > MAG_W'(MAG_LIMIT)) begin
          mag_nxt = MAG_LIMIT;
        end else begin
          mag_nxt = mag_sum[30:0];
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          value_nxt     = (flags_r.neg && !flags_r.err) ? -VALUE_W'(mag_r)
                                                        : VALUE_W'(mag_r);
          err_out_nxt   = flags_r.err;
          ovf_out_nxt   = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    flags_r   <= flags_nxt;
    int_r     <= int_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    dcnt_r    <= dcnt_nxt;
    mag_r     <= mag_nxt;
    ovf_r     <= ovf_nxt;
    value_r   <= value_nxt;
    err_out_r <= err_out_nxt;
    ovf_out_r <= ovf_out_nxt;
  end

endmodule

@@ src/decimal_string_to_fixed.sv @@
// decimal_string_to_fixed: top level. ASCII decimal string in, signed fixed
// point with FRAC_BITS fraction bits out. Depends on dstf_pkg, dstf_front,
// dstf_job_queue and dstf_back.
//
//   channel   ports                                     handshake
//   input     in_char_code                              in_push / in_full
//   result    out_value, out_format_error, out_overflow out_pop / out_empty
//
// One character beat per cycle while in_full is low; the terminator ends a string
// and queues a job. Each job passes through the converter's load, FRAC_BITS + 1
// steps of the restoring divider, round and deliver; that divider sets the rate.
// Up to two finished strings wait in the job queue; in_full rises when it is full.
// Result stalls (out_pop low) hold the converter in its deliver step only.
// rst_n is synchronous and clears parser state, queue and result valid.
module decimal_string_to_fixed
  import dstf_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [7:0]                in_char_code,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_format_error,
  output logic                      out_overflow
);

  localparam int INT_W  = (FRAC_BITS >= 31) ? 1 : 31 - FRAC_BITS;
  localparam int FRAC_W = $clog2(POW10[MAX_FRAC_DIGITS]);
  localparam int CNT_W  = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int FLG_W  = $bits(job_flags_t);
  localparam int JOB_W  = FLG_W + INT_W + FRAC_W + CNT_W;

  logic              in_beat;
  logic              job_push, job_pop, job_empty;
  job_flags_t        f_flags, b_flags;
  logic [INT_W-1:0]  f_int, b_int;
  logic [FRAC_W-1:0] f_frac, b_frac;
  logic [CNT_W-1:0]  f_cnt, b_cnt;
  logic [JOB_W-1:0]  push_data, pop_data;

  assign in_beat   = in_push && !in_full;
  assign push_data = {f_flags, f_int, f_frac, f_cnt};
  assign {b_flags, b_int, b_frac, b_cnt} = pop_data;

  // Parser
  dstf_front #(
    .FRAC_BITS      (FRAC_BITS),
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
    .INT_W          (INT_W),
    .FRAC_W         (FRAC_W),
    .CNT_W          (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_valid(in_beat),
    .char_code (in_char_code),
    .job_push  (job_push),
    .job_flags (f_flags),
    .job_int   (f_int),
    .job_frac  (f_frac),
    .job_cnt   (f_cnt)
  );

  // Job queue
  dstf_job_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data(push_data),
    .full     (in_full),
    .pop      (job_pop),
    .pop_data (pop_data),
    .empty    (job_empty)
  );

  // Converter and result register
  dstf_back #(
    .FRAC_BITS      (FRAC_BITS),
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
    .INT_W          (INT_W),
    .FRAC_W         (FRAC_W),
    .CNT_W          (CNT_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_empty       (job_empty),
    .job_pop         (job_pop),
    .job_flags       (b_flags),
    .job_int         (b_int),
    .job_frac        (b_frac),
    .job_cnt         (b_cnt),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_value       (out_value),
    .out_format_error(out_format_error),
    .out_overflow    (out_overflow)
  );

  // A format error result carries zero and no overflow
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_format_error |-> out_value == '0 && !out_overflow)
    else $error("format error result not zero");

  // Overflow result is the largest magnitude of either sign
  a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_overflow |->
      (out_value == 32'sh7FFF_FFFF || out_value == -32'sh7FFF_FFFF))
    else $error("overflow result not saturated");

  // The most negative code never appears
  a_no_minint: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_value != 32'sh8000_0000)
    else $error("result outside symmetric range");

endmodule
